// ----- hdl/sld_pkg.sv -----
package sld_pkg;

  localparam int unsigned TIMEOUT_W  = 16;
  localparam int unsigned MAXLINE_W  = 10;
  localparam int unsigned ELAPSED_W  = 17;
  localparam int unsigned DUR_W      = 32;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = 16'd4000;
  localparam logic [MAXLINE_W-1:0] MAXLINE_RST = 10'd229;
  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;
  localparam logic [7:0]           SENTINEL    = 8'hff;

  localparam logic [1:0] OP_DATA  = 2'd0;
  localparam logic [1:0] OP_TICK  = 2'd1;
  localparam logic [1:0] OP_START = 2'd2;

  localparam logic [2:0] KIND_DURATION = 3'd0;
  localparam logic [2:0] KIND_COORD    = 3'd1;
  localparam logic [2:0] KIND_EOP      = 3'd2;
  localparam logic [2:0] KIND_OVERRUN  = 3'd3;
  localparam logic [2:0] KIND_TIMEOUT  = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAXLINE = 1'd1;

  typedef struct packed {
    logic                  active;
    logic                  halted;
    logic [MAXLINE_W-1:0]  byte_count;
    logic [DUR_W-1:0]      duration_shift;
    logic [DUR_W-1:0]      recent_bytes;
    logic [ELAPSED_W-1:0]  elapsed_ms;
  } state_t;

  typedef struct packed {
    logic [2:0]       kind;
    logic [DUR_W-1:0] duration_ms;
    logic [3:0]       coord_x;
    logic [3:0]       coord_y;
    logic             last;
  } result_t;

endpackage

// ----- hdl/sld_parse.sv -----
module sld_parse (
  input  logic [1:0]                      op,
  input  logic [7:0]                      data_byte,
  input  sld_pkg::state_t                 state,
  input  logic [sld_pkg::TIMEOUT_W-1:0]   timeout_ms,
  input  logic [sld_pkg::MAXLINE_W-1:0]   max_line_bytes,
  output sld_pkg::state_t                 state_nxt,
  output logic                            res_valid,
  output sld_pkg::result_t                res
);

  logic [sld_pkg::DUR_W-1:0]     recent_nxt;
  logic [sld_pkg::MAXLINE_W-1:0] count_nxt;
  logic [sld_pkg::ELAPSED_W-1:0] elapsed_nxt;
  logic [7:0]                    leaving;
  logic                          eol;

  assign leaving     = state.recent_bytes[31:24];
  assign recent_nxt  = {state.recent_bytes[23:0], data_byte};
  assign count_nxt   = state.byte_count + 10'd1;
  assign elapsed_nxt = (state.elapsed_ms < sld_pkg::ELAPSED_MAX) ?
                       state.elapsed_ms + 17'd1 : state.elapsed_ms;
  assign eol         = (count_nxt >= 10'd4) && (recent_nxt == '1);

  always_comb begin
    state_nxt = state;
    res_valid = 1'b0;
    res       = '0;
    if (!state.halted) begin
      case (op)
        sld_pkg::OP_START: begin
          state_nxt.active         = 1'b1;
          state_nxt.elapsed_ms     = '0;
          state_nxt.byte_count     = '0;
          state_nxt.duration_shift = '0;
          state_nxt.recent_bytes   = '0;
        end
        sld_pkg::OP_TICK: begin
          if (state.active) begin
            state_nxt.elapsed_ms = elapsed_nxt;
            if (elapsed_nxt > {1'b0, timeout_ms}) begin
              state_nxt.active         = 1'b0;
              state_nxt.byte_count     = '0;
              state_nxt.duration_shift = '0;
              state_nxt.recent_bytes   = '0;
              res_valid                = 1'b1;
              res.kind                 = sld_pkg::KIND_TIMEOUT;
            end
          end
        end
        sld_pkg::OP_DATA: begin
          if (state.active) begin
            if (state.byte_count >= max_line_bytes) begin
              state_nxt.halted = 1'b1;
              state_nxt.active = 1'b0;
              res_valid        = 1'b1;
              res.kind         = sld_pkg::KIND_OVERRUN;
            end else begin
              state_nxt.recent_bytes = recent_nxt;
              state_nxt.byte_count   = count_nxt;
              if (state.byte_count < 10'd4) begin
                state_nxt.duration_shift = {state.duration_shift[23:0], data_byte};
              end
              if (eol) begin
                state_nxt.byte_count     = '0;
                state_nxt.duration_shift = '0;
                state_nxt.recent_bytes   = '0;
                res_valid                = 1'b1;
                if (count_nxt == 10'd4) begin
                  state_nxt.active = 1'b0;
                  res.kind         = sld_pkg::KIND_EOP;
                end else if (count_nxt <= 10'd8) begin
                  res.kind        = sld_pkg::KIND_DURATION;
                  res.duration_ms = state.duration_shift;
                  res.last        = 1'b1;
                end else begin
                  res.kind    = sld_pkg::KIND_COORD;
                  res.coord_x = leaving[7:4];
                  res.coord_y = leaving[3:0];
                  res.last    = 1'b1;
                end
              end else if (count_nxt == 10'd8) begin
                res_valid       = 1'b1;
                res.kind        = sld_pkg::KIND_DURATION;
                res.duration_ms = state.duration_shift;
              end else if (count_nxt > 10'd8) begin
                res_valid   = 1'b1;
                res.kind    = sld_pkg::KIND_COORD;
                res.coord_x = leaving[7:4];
                res.coord_y = leaving[3:0];
              end
            end
          end
        end
        default: begin
          state_nxt = state;
        end
      endcase
    end
  end

endmodule

// ----- hdl/sentinel_line_deframer_core.sv -----
// channel | direction | handshake          | payload
// in_     | input     | in_valid/in_stall  | in_op, in_data_byte
// out_    | output    | out_valid/out_stall| out_kind, out_duration_ms, out_coord_x,
//         |           |                    | out_coord_y, out_last
// cfg_    | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
// One word a cycle while in_stall is low: each word is parsed in the cycle it is
// taken, and its result is registered in the output stage (or the second stage).
// A second output stage holds a result while the output is stalled; in_stall
// rises only while that stage is full. cfg_ready is always high.
// rst_n (synchronous) clears the parser, flags, elapsed count, registers to
// their defaults and both output stages.
module sentinel_line_deframer_core (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [1:0]                       in_op,
  input  logic [7:0]                       in_data_byte,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [2:0]                       out_kind,
  output logic [31:0]                      out_duration_ms,
  output logic [3:0]                       out_coord_x,
  output logic [3:0]                       out_coord_y,
  output logic                             out_last,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [sld_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sld_pkg::CFG_DATA_W-1:0]   cfg_data
);

  sld_pkg::state_t               state_r;
  sld_pkg::state_t               state_nxt;
  logic [sld_pkg::TIMEOUT_W-1:0] timeout_r;
  logic [sld_pkg::MAXLINE_W-1:0] maxline_r;
  sld_pkg::result_t              res;
  logic                          res_valid;
  sld_pkg::result_t              out_r;
  logic                          out_valid_r;
  sld_pkg::result_t              skid_r;
  logic                          skid_valid_r;
  logic                          in_take;
  logic                          out_take;
  logic                          fire;

  assign in_stall  = skid_valid_r;
  assign cfg_ready = 1'b1;
  assign in_take   = in_valid && !in_stall;
  assign out_take  = out_valid_r && !out_stall;
  assign fire      = in_take && res_valid;

  sld_parse u_parse (
    .op             (in_op),
    .data_byte      (in_data_byte),
    .state          (state_r),
    .timeout_ms     (timeout_r),
    .max_line_bytes (maxline_r),
    .state_nxt      (state_nxt),
    .res_valid      (res_valid),
    .res            (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= '0;
      timeout_r <= sld_pkg::TIMEOUT_RST;
      maxline_r <= sld_pkg::MAXLINE_RST;
    end else begin
      if (in_take) begin
        state_r <= state_nxt;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          sld_pkg::CFG_TIMEOUT: timeout_r <= cfg_data;
          sld_pkg::CFG_MAXLINE: maxline_r <= cfg_data[sld_pkg::MAXLINE_W-1:0];
          default: begin
            timeout_r <= timeout_r;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_take) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end
    end else if (!out_valid_r || out_take) begin
      out_valid_r <= fire;
    end else begin
      skid_valid_r <= fire;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_take) begin
        out_r <= skid_r;
      end
    end else if (!out_valid_r || out_take) begin
      if (fire) begin
        out_r <= res;
      end
    end else if (fire) begin
      skid_r <= res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_kind        = out_r.kind;
  assign out_duration_ms = out_r.duration_ms;
  assign out_coord_x     = out_r.coord_x;
  assign out_coord_y     = out_r.coord_y;
  assign out_last        = out_r.last;

  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid stage full with output stage empty");

  a_halt_not_active: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.halted |-> !state_r.active)
    else $error("halted while active");

  a_skid_holds: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r && out_stall |=> skid_valid_r && $stable(skid_r))
    else $error("skid word lost or changed under stall");

  a_flag_kinds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.last |->
      (out_r.kind == sld_pkg::KIND_DURATION || out_r.kind == sld_pkg::KIND_COORD))
    else $error("end-of-line flag on a status word");

  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.halted |=> state_r.halted)
    else $error("halt cleared without reset");

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 100ps
module tb_top;
  import sld_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int CHK_PRED = 0;
  localparam int CHK_NONE = 1;
  localparam int CHK_RES = 2;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_WORDS = 200;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] b;
  } word_t;

  typedef struct {
    word_t   w;
    int      chk;
    result_t res;
  } row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [1:0]            in_op = OP_DATA;
  logic [7:0]            in_data_byte = 8'h00;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [2:0]            out_kind;
  logic [31:0]           out_duration_ms;
  logic [3:0]            out_coord_x;
  logic [3:0]            out_coord_y;
  logic                  out_last;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_TIMEOUT;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // predicted block state and registers
  logic                 p_active = 1'b0;
  logic                 p_halted = 1'b0;
  logic [MAXLINE_W-1:0] p_count = '0;
  logic [DUR_W-1:0]     p_dur = '0;
  logic [DUR_W-1:0]     p_recent = '0;
  logic [ELAPSED_W-1:0] p_elapsed = '0;
  logic [TIMEOUT_W-1:0] p_timeout = TIMEOUT_RST;
  logic [MAXLINE_W-1:0] p_maxline = MAXLINE_RST;

  result_t due_results [$];
  word_t   plan_q [$];
  row_t    steps [$];
  int      errors = 0;
  bit      calm = 1'b0;
  bit      hold_req = 1'b0;
  bit      hold_used = 1'b0;
  int      hold_left = 0;
  int      row_chk = CHK_PRED;
  result_t row_res = '0;

  sentinel_line_deframer_core dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_op           (in_op),
    .in_data_byte    (in_data_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_kind        (out_kind),
    .out_duration_ms (out_duration_ms),
    .out_coord_x     (out_coord_x),
    .out_coord_y     (out_coord_y),
    .out_last        (out_last),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic void clear_line();
    p_count = '0;
    p_dur = '0;
    p_recent = '0;
  endfunction

  function automatic bit deframe_word(input logic [1:0] op, input logic [7:0] b,
                                      output result_t r);
    logic [7:0] leaving;
    bit         eol;
    r = '0;
    if (p_halted) return 1'b0;
    if (op == OP_START) begin
      p_active = 1'b1;
      p_elapsed = '0;
      clear_line();
      return 1'b0;
    end
    if (!p_active) return 1'b0;
    if (op == OP_TICK) begin
      if (p_elapsed != ELAPSED_MAX) p_elapsed = p_elapsed + 1'b1;
      if (p_elapsed > p_timeout) begin
        p_active = 1'b0;
        clear_line();
        r.kind = KIND_TIMEOUT;
        return 1'b1;
      end
      return 1'b0;
    end
    if (op != OP_DATA) return 1'b0;
    if (p_count >= p_maxline) begin
      p_halted = 1'b1;
      p_active = 1'b0;
      r.kind = KIND_OVERRUN;
      return 1'b1;
    end
    leaving = p_recent[31:24];
    p_recent = {p_recent[23:0], b};
    if (p_count < 10'd4) p_dur = {p_dur[23:0], b};
    p_count = p_count + 1'b1;
    eol = (p_count >= 10'd4) && (p_recent == '1);
    if (eol && p_count == 10'd4) begin
      p_active = 1'b0;
      clear_line();
      r.kind = KIND_EOP;
      return 1'b1;
    end
    if (eol && p_count <= 10'd8) begin
      r.kind = KIND_DURATION;
      r.duration_ms = p_dur;
      r.last = 1'b1;
      clear_line();
      return 1'b1;
    end
    if (eol) begin
      r.kind = KIND_COORD;
      {r.coord_x, r.coord_y} = leaving;
      r.last = 1'b1;
      clear_line();
      return 1'b1;
    end
    if (p_count == 10'd8) begin
      r.kind = KIND_DURATION;
      r.duration_ms = p_dur;
      return 1'b1;
    end
    if (p_count > 10'd8) begin
      r.kind = KIND_COORD;
      {r.coord_x, r.coord_y} = leaving;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  always @(posedge clk) begin : monitor
    result_t got;
    result_t want;
    bit      has;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        got = {out_kind, out_duration_ms, out_coord_x, out_coord_y, out_last};
        if (due_results.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("%0t: unexpected word kind=%0d dur=%h x=%h y=%h last=%b", $time,
                     got.kind, got.duration_ms, got.coord_x, got.coord_y, got.last);
        end else begin
          want = due_results.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= 10)
              $display({"%0t: mismatch exp kind=%0d dur=%h x=%h y=%h last=%b",
                        " got kind=%0d dur=%h x=%h y=%h last=%b"}, $time,
                       want.kind, want.duration_ms, want.coord_x, want.coord_y, want.last,
                       got.kind, got.duration_ms, got.coord_x, got.coord_y, got.last);
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_TIMEOUT: p_timeout = cfg_data[TIMEOUT_W-1:0];
          CFG_MAXLINE: p_maxline = cfg_data[MAXLINE_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        has = deframe_word(in_op, in_data_byte, want);
        if (row_chk == CHK_NONE) has = 1'b0;
        if (row_chk == CHK_RES) begin
          has = 1'b1;
          want = row_res;
        end
        if (has) due_results.push_back(want);
      end
    end
  end

  initial begin : receiver
    forever begin
      @(negedge clk);
      if (hold_req && !hold_used) begin
        hold_used = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall = 1'b1;
        hold_left--;
      end else begin
        out_stall = !calm && ($urandom_range(99) < 21);
      end
    end
  end

  initial begin : watchdog
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic row_t row(input logic [1:0] op, input logic [7:0] b, input int chk,
                               input logic [2:0] kind, input logic [31:0] dur,
                               input logic [7:0] cb, input logic last);
    row_t s;
    s.w = {op, b};
    s.chk = chk;
    s.res = {kind, dur, cb[7:4], cb[3:0], last};
    return s;
  endfunction

  task automatic send_word(input logic [1:0] op, input logic [7:0] b);
    while (!calm && $urandom_range(99) < 21) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_op = op;
    in_data_byte = b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic settle();
    in_valid = 1'b0;
    while (due_results.size() != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  function automatic logic [7:0] line_byte();
    return ($urandom_range(7) == 0) ? 8'hff : 8'($urandom_range(255));
  endfunction

  function automatic void plan_data(input logic [7:0] b, input int tick_pct);
    if ($urandom_range(99) < tick_pct) plan_q.push_back({OP_TICK, 8'($urandom_range(255))});
    plan_q.push_back({OP_DATA, b});
  endfunction

  function automatic void plan_program(input int tick_pct);
    int r;
    int n;
    if (!p_active && $urandom_range(99) < 90) plan_q.push_back({OP_START, 8'h00});
    r = $urandom_range(99);
    if (r < 60) begin
      n = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(5);
      repeat (4 + n) plan_data(line_byte(), tick_pct);
      repeat (4) plan_data(SENTINEL, tick_pct);
    end else if (r < 70) begin
      repeat (4) plan_data(SENTINEL, tick_pct);
    end else if (r < 80) begin
      plan_q.push_back({OP_START, 8'($urandom_range(255))});
    end else if (r < 90) begin
      repeat ($urandom_range(6, 1)) plan_data(line_byte(), tick_pct);
      plan_q.push_back({OP_START, 8'h00});
    end else begin
      repeat ($urandom_range(4, 1))
        plan_q.push_back({2'($urandom_range(3)), 8'($urandom_range(255))});
    end
  endfunction

  task automatic run_phase(input int tmo, input int maxline, input int tick_pct,
                           input bit quiet);
    int    n;
    word_t w;
    settle();
    write_reg(CFG_TIMEOUT, 16'(tmo));
    write_reg(CFG_MAXLINE, {6'($urandom_range(63)), 10'(maxline)});
    calm = quiet;
    n = 0;
    plan_q.delete();
    while (n < PHASE_WORDS) begin
      if (plan_q.size() == 0) plan_program(tick_pct);
      w = plan_q.pop_front();
      // keep the block out of its halted state until the last phase
      if (w.op == OP_DATA && p_active && p_count >= p_maxline) begin
        w.op = OP_START;
        plan_q.delete();
      end
      if (!p_halted && (p_active || w.op == OP_START)) n++;
      send_word(w.op, w.b);
    end
    calm = 1'b0;
  endtask

  initial begin : driver
    int i;
    steps.push_back(row(OP_DATA,   8'h00, CHK_NONE, KIND_DURATION, 32'd0, 8'h00, 1'b0));
    steps.push_back(row(OP_TICK,   8'hff, CHK_NONE, KIND_DURATION, 32'd0, 8'h00, 1'b0));
    steps.push_back(row(OP_START,  8'h00, CHK_NONE, KIND_DURATION, 32'd0, 8'h00, 1'b0));
    steps.push_back(row(OP_UNUSED, 8'hff, CHK_NONE, KIND_DURATION, 32'd0, 8'h00, 1'b0));
    steps.push_back(row(OP_DATA,   8'h12, CHK_PRED, KIND_DURATION, 32'd0, 8'h00, 1'b0));
    steps.push_back(row(OP_START,  8'hff, CHK_NONE, KIND_DURATION, 32'd0, 8'h00, 1'b0));
    for (i = 0; i < 4; i++)
      steps.push_back(row(OP_DATA, 8'h00, CHK_PRED, KIND_DURATION, 32'd0, 8'h00, 1'b0));
    steps.push_back(row(OP_DATA,   8'hf0, CHK_PRED, KIND_DURATION, 32'd0, 8'h00, 1'b0));
    steps.push_back(row(OP_DATA,   8'hff, CHK_PRED, KIND_DURATION, 32'd0, 8'h00, 1'b0));
    steps.push_back(row(OP_DATA,   8'hff, CHK_PRED, KIND_DURATION, 32'd0, 8'h00, 1'b0));
    steps.push_back(row(OP_DATA,   8'hff, CHK_RES,  KIND_DURATION, 32'd0, 8'h00, 1'b0));
    steps.push_back(row(OP_DATA,   8'hff, CHK_RES,  KIND_COORD,    32'd0, 8'hf0, 1'b1));
    steps.push_back(row(OP_DATA,   8'h12, CHK_PRED, KIND_DURATION, 32'd0, 8'h00, 1'b0));
    steps.push_back(row(OP_DATA,   8'h34, CHK_PRED, KIND_DURATION, 32'd0, 8'h00, 1'b0));
    steps.push_back(row(OP_DATA,   8'h56, CHK_PRED, KIND_DURATION, 32'd0, 8'h00, 1'b0));
    for (i = 0; i < 3; i++)
      steps.push_back(row(OP_DATA, 8'hff, CHK_PRED, KIND_DURATION, 32'd0, 8'h00, 1'b0));
    steps.push_back(row(OP_DATA, 8'hff, CHK_RES, KIND_DURATION, 32'h123456ff, 8'h00, 1'b1));
    for (i = 0; i < 3; i++)
      steps.push_back(row(OP_DATA, 8'hff, CHK_PRED, KIND_DURATION, 32'd0, 8'h00, 1'b0));
    steps.push_back(row(OP_DATA,   8'hff, CHK_RES,  KIND_EOP,      32'd0, 8'h00, 1'b0));
    steps.push_back(row(OP_TICK,   8'h00, CHK_NONE, KIND_DURATION, 32'd0, 8'h00, 1'b0));

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (steps[k]) begin
      row_chk = steps[k].chk;
      row_res = steps[k].res;
      send_word(steps[k].w.op, steps[k].w.b);
    end
    row_chk = CHK_PRED;

    run_phase(20, 64, 15, 1'b0);
    run_phase(1, 8, 5, 1'b0);
    run_phase(0, 1023, 3, 1'b0);
    run_phase(65535, 1023, 20, 1'b1);
    run_phase(300, 229, 6, 1'b0);

    // hold the receiver off through one long line so the output backs up
    settle();
    write_reg(CFG_TIMEOUT, 16'hffff);
    write_reg(CFG_MAXLINE, 16'd1023);
    calm = 1'b1;
    hold_req = 1'b1;
    send_word(OP_START, 8'h00);
    repeat (124) send_word(OP_DATA, 8'($urandom_range(254)));
    repeat (4) send_word(OP_DATA, SENTINEL);
    calm = 1'b0;

    // overrun last: it halts the block for the rest of the run
    settle();
    write_reg(CFG_MAXLINE, 16'd16);
    send_word(OP_START, 8'h00);
    repeat (20) send_word(OP_DATA, 8'($urandom_range(254)));
    send_word(OP_START, 8'h00);
    send_word(OP_TICK, 8'h00);
    for (i = 0; i < 12; i++) send_word(OP_DATA, (i < 8) ? 8'h21 : SENTINEL);

    settle();
    repeat (20) @(negedge clk);
    if (errors == 0 && due_results.size() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
